[rtl/longest_prefix_route_lookup_assert.svh]
// Assertion macros used by the route lookup checker.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lprl_pkg.sv]
package lprl_pkg;

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 2;
  localparam int IDX_FIELD_W = 4;

  // Default configuration
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_NUM_PORTS   = 4;

  // Stream widths (padded to whole bytes)
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  // Opcodes carried on in_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } lprl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;
    logic start;
    logic rd;
    logic load_out;
  } lprl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic out_busy;
  } lprl_sts_t;

endpackage

[rtl/lprl_ctrl.sv]
module lprl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  input  lprl_pkg::lprl_sts_t sts,
  output lprl_pkg::lprl_cmd_t cmd
);
  import lprl_pkg::*;

  lprl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_tuser == OP_LOOKUP)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.wr_en = in_tvalid && (in_tuser == OP_WRITE);
        cmd.start = in_tvalid && (in_tuser == OP_LOOKUP);
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/lprl_dp.sv]
module lprl_dp #(
  parameter int TABLE_DEPTH = lprl_pkg::DEF_TABLE_DEPTH,
  parameter int NUM_PORTS   = lprl_pkg::DEF_NUM_PORTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lprl_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  lprl_pkg::lprl_cmd_t               cmd,
  output lprl_pkg::lprl_sts_t               sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lprl_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import lprl_pkg::*;

  // Only the slots an index field can reach are stored
  localparam int MAX_SLOTS  = 1 << IDX_FIELD_W;
  localparam int SCAN_DEPTH = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
  localparam int IDX_W      = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;

  // Request fields
  logic [IDX_FIELD_W-1:0] f_index;
  logic [ADDR_W-1:0]      f_prefix;
  logic [ADDR_W-1:0]      f_mask;
  logic [PORT_W-1:0]      f_port;
  logic                   f_valid;
  logic [ADDR_W-1:0]      f_addr;
  logic [PORT_W-1:0]      wr_port;

  assign f_index  = in_tdata[3:0];
  assign f_prefix = in_tdata[35:4];
  assign f_mask   = in_tdata[67:36];
  assign f_port   = in_tdata[69:68];
  assign f_valid  = in_tdata[70];
  assign f_addr   = in_tdata[102:71];

  // Clamp ports beyond the last interface
  assign wr_port = (32'(f_port) >= NUM_PORTS) ? PORT_W'(NUM_PORTS - 1) : f_port;

  // Route table
  logic [ADDR_W-1:0] prefix_mem [SCAN_DEPTH];
  logic [ADDR_W-1:0] mask_mem   [SCAN_DEPTH];
  logic [PORT_W-1:0] port_mem   [SCAN_DEPTH];
  logic [SCAN_DEPTH-1:0] valid_r;

  logic              wr_ok;
  logic [IDX_W-1:0]  wr_idx;

  assign wr_ok  = cmd.wr_en && (32'(f_index) < SCAN_DEPTH);
  assign wr_idx = f_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      prefix_mem[wr_idx] <= f_prefix;
      mask_mem[wr_idx]   <= f_mask;
      port_mem[wr_idx]   <= wr_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_idx] <= f_valid;
    end
  end

  // Scan counter and registered table read
  logic [IDX_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] rd_prefix_r;
  logic [ADDR_W-1:0] rd_mask_r;
  logic [PORT_W-1:0] rd_port_r;
  logic              rd_valid_r;
  logic              rd_pend_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt_r  <= '0;
      addr_r <= f_addr;
    end else if (cmd.rd) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
    if (cmd.rd) begin
      rd_prefix_r <= prefix_mem[cnt_r];
      rd_mask_r   <= mask_mem[cnt_r];
      rd_port_r   <= port_mem[cnt_r];
      rd_valid_r  <= valid_r[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd;
    end
  end

  assign sts.last = (cnt_r == IDX_W'(SCAN_DEPTH - 1));

  // Best-match compare
  logic              found_r;
  logic [ADDR_W-1:0] best_mask_r;
  logic [PORT_W-1:0] best_port_r;
  logic              take;

  assign take = rd_pend_r && rd_valid_r &&
                (!found_r || (best_mask_r == '0) || (rd_mask_r > best_mask_r)) &&
                ((addr_r & rd_mask_r) == rd_prefix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      best_mask_r <= '0;
      best_port_r <= '0;
    end else if (cmd.start) begin
      found_r     <= 1'b0;
      best_mask_r <= '0;
      best_port_r <= '0;
    end else if (take) begin
      found_r     <= 1'b1;
      best_mask_r <= rd_mask_r;
      best_port_r <= rd_port_r;
    end
  end

  // Output register
  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [PORT_W-1:0]      out_port_r;
  logic [ADDR_W-1:0]      out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r  <= found_r;
      out_port_r <= found_r ? best_port_r : '0;
      out_mask_r <= found_r ? best_mask_r : '0;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(OUT_TDATA_W - 1 - PORT_W - ADDR_W){1'b0}},
                         out_mask_r, out_port_r, out_hit_r};

endmodule

[rtl/longest_prefix_route_lookup.sv]
// Timing: a write request is stored at the clock edge that accepts it; a lookup passes
// through the scan, drain and done states, and its result is registered onto out_tvalid.
// Throughput: one write per cycle while idle; no request is taken during a lookup, as the
// single compare unit walks the table one slot per cycle through a registered read, and
// the result load also waits while a stalled out_tready still holds the previous result.
// Reset: synchronous, active-low rst_n clears all valid bits, the controller and the
// output valid; stored prefixes, masks and ports are kept until overwritten.
module longest_prefix_route_lookup #(
  parameter int TABLE_DEPTH = lprl_pkg::DEF_TABLE_DEPTH,
  parameter int NUM_PORTS   = lprl_pkg::DEF_NUM_PORTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata fields, low bit up: entry_index[4], route_prefix[32], route_mask[32],
  // route_port[2], route_valid[1], lookup_address[32], zero pad[1]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lprl_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,   // opcode: 0 write, 1 lookup
  // out_tdata fields, low bit up: hit[1], out_port[2], matched_mask[32], zero pad[5]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lprl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lprl_pkg::*;

  lprl_cmd_t cmd;
  lprl_sts_t sts;

  // Sequencer
  lprl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, compare unit and output register
  lprl_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .NUM_PORTS   (NUM_PORTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/lprl_checker.sv]
`include "longest_prefix_route_lookup_assert.svh"

module lprl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lprl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lprl_pkg::*;

  logic in_acc;
  logic miss_shown;

  assign in_acc     = in_tvalid && in_tready;
  assign miss_shown = out_tvalid && !out_tdata[0];

  // A stalled result holds
  `LPRL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A miss reports port and mask as zero
  `LPRL_ASSERT_NOW(a_miss_zero, clk, rst_n, miss_shown, out_tdata[34:1] == '0, "miss with nonzero port or mask")

  // A lookup occupies the block for the scan
  `LPRL_ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_acc && (in_tuser == OP_LOOKUP), !in_tready, "request taken during scan")

  // A write never blocks the next request
  `LPRL_ASSERT_NEXT(a_write_ready, clk, rst_n, in_acc && (in_tuser == OP_WRITE), in_tready, "ready dropped after write")

endmodule

bind longest_prefix_route_lookup lprl_checker u_lprl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
